// File: sv/spq_pkg.sv
package spq_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// File: sv/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/stable_priority_queue_core.sv
// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_ready     i_action, i_value_in, i_priority_in
// output   out        o_out_valid / i_out_ready   o_status, o_value_out, o_priority_out
//
// Entries sit in a circular buffer in one RAM (registered read, one write port).
// An enqueue walks back from the tail; each entry visited takes a RAM read, then a
// compare and write. The walk stops on an entry of equal or higher priority; when
// all entries move, the new entry goes to the head slot. A dequeue reads the head
// entry from RAM, then takes its data. The sequencer returns to idle before the
// next request is taken.
// Reset clears occupancy, pointers, state and output valid; RAM contents are left as they are.
// One request is in work at a time; the result waits in the output register
// while the next request may already be accepted.
module stable_priority_queue_core #(
    parameter int CAPACITY      = 16,
    parameter int DATA_BITS     = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic [DATA_BITS-1:0]     i_value_in,
    input  logic [PRIORITY_BITS-1:0] i_priority_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output spq_pkg::t_status         o_status,
    output logic [DATA_BITS-1:0]     o_value_out,
    output logic [PRIORITY_BITS-1:0] o_priority_out
);

    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int EW = DATA_BITS + PRIORITY_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERD,
        S_ECMP,
        S_EPUT,
        S_DRD,
        S_DDAT,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [OW-1:0]            r_occ;
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_tail;
    logic [AW-1:0]            r_cursor;
    logic [OW-1:0]            r_left;
    logic [DATA_BITS-1:0]     r_val;
    logic [PRIORITY_BITS-1:0] r_pri;
    t_status                  r_res_status;
    logic [DATA_BITS-1:0]     r_res_val;
    logic [PRIORITY_BITS-1:0] r_res_pri;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [DATA_BITS-1:0]     r_out_val;
    logic [PRIORITY_BITS-1:0] r_out_pri;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [EW-1:0]            ram_rdata;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic                     rd_ge;
    logic [EW-1:0]            new_entry;

    // circular pointer steps
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        if (a == AW'(CAPACITY - 1)) begin
            return '0;
        end
        return a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        if (a == '0) begin
            return AW'(CAPACITY - 1);
        end
        return a - 1'b1;
    endfunction

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entry packing: priority above value
    assign new_entry = {r_pri, r_val};
    assign rd_pri    = ram_rdata[EW-1 -: PRIORITY_BITS];
    assign rd_ge     = (rd_pri >= r_pri);

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cursor;
        ram_wdata = new_entry;
        ram_raddr = (r_state == S_DRD) ? r_head : r_cursor;
        case (r_state)
            S_ECMP: begin
                // stop: new entry after this one; else shift this one back
                ram_we    = 1'b1;
                ram_waddr = wrap_inc(r_cursor);
                ram_wdata = rd_ge ? new_entry : ram_rdata;
            end
            S_EPUT: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load from done, clear when taken
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val <= i_value_in;
                        r_pri <= i_priority_in;
                        if (!i_action) begin
                            r_res_val <= i_value_in;
                            r_res_pri <= i_priority_in;
                            if (r_occ == OW'(CAPACITY)) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_DONE;
                            end else if (r_occ == '0) begin
                                r_cursor <= r_tail;
                                r_state  <= S_EPUT;
                            end else begin
                                r_cursor <= wrap_dec(r_tail);
                                r_left   <= r_occ;
                                r_state  <= S_ERD;
                            end
                        end else begin
                            if (r_occ == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_res_val    <= '0;
                                r_res_pri    <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_DRD;
                            end
                        end
                    end
                end
                S_ERD: begin
                    r_state <= S_ECMP;
                end
                S_ECMP: begin
                    if (rd_ge) begin
                        r_tail       <= wrap_inc(r_tail);
                        r_occ        <= r_occ + 1'b1;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end else if (r_left == OW'(1)) begin
                        // walked past the front: new entry goes to the head slot
                        r_state <= S_EPUT;
                    end else begin
                        r_left   <= r_left - 1'b1;
                        r_cursor <= wrap_dec(r_cursor);
                        r_state  <= S_ERD;
                    end
                end
                S_EPUT: begin
                    r_tail       <= wrap_inc(r_tail);
                    r_occ        <= r_occ + 1'b1;
                    r_res_status <= ST_OK;
                    r_state      <= S_DONE;
                end
                S_DRD: begin
                    r_state <= S_DDAT;
                end
                S_DDAT: begin
                    r_res_val    <= ram_rdata[DATA_BITS-1:0];
                    r_res_pri    <= rd_pri;
                    r_res_status <= ST_OK;
                    r_head       <= wrap_inc(r_head);
                    r_occ        <= r_occ - 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_status <= r_res_status;
                        r_out_val    <= r_res_val;
                        r_out_pri    <= r_res_pri;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value_out    = r_out_val;
    assign o_priority_out = r_out_pri;

endmodule
